[rtl/ghash_pkg.sv]
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types, codes and modular helpers for the grid rectangle hash core.
// ----------------------------------------------------------------------------
package ghash_pkg;

    localparam int HW = 61;
    localparam logic [HW-1:0] HMOD = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [HW-1:0] FERMAT_EXP = HMOD - 61'd2;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [HW-1:0] ROW_BASE_RST = 61'd1000000007;
    localparam logic [HW-1:0] COL_BASE_RST = 61'd100000007;
    localparam logic [6:0]    GRID_DIM_RST = 7'd64;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_BUILD  = 2'd0;
    localparam logic [1:0] KIND_HASH   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] CFG_ROW_BASE    = 2'd0;
    localparam logic [1:0] CFG_COL_BASE    = 2'd1;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd3;

    typedef struct packed {
        logic [1:0]    operation;
        logic [5:0]    cell_row;
        logic [5:0]    cell_col;
        logic [HW-1:0] cell_value;
        logic [6:0]    top_row;
        logic [6:0]    left_col;
        logic [6:0]    bottom_row;
        logic [6:0]    right_col;
    } cmd_t;

    typedef struct packed {
        logic [HW-1:0] hash_value;
        logic [1:0]    result_kind;
    } res_t;

    // address width for a memory of the given depth
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic [HW-1:0] mreduce(input logic [HW-1:0] v);
        return (v == HMOD) ? '0 : v;
    endfunction

    function automatic logic [HW-1:0] madd(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [HW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HMOD})
        begin
            s = s - {1'b0, HMOD};
        end
        return s[HW-1:0];
    endfunction

    function automatic logic [HW-1:0] msub(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [HW:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + {1'b0, HMOD} - {1'b0, b};
        end
        return s[HW-1:0];
    endfunction

endpackage

[rtl/ghash_ram.sv]
// ----------------------------------------------------------------------------
// ghash_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghash_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [ghash_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [ghash_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ghash_mulmod.sv]
// ----------------------------------------------------------------------------
// ghash_mulmod
// Iterative a*b mod 2^61-1: four 31x31 partial products on one multiplier,
// folded into an accumulator, then a final Mersenne reduction.
// ----------------------------------------------------------------------------
module ghash_mulmod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ghash_pkg::HW-1:0] a,
    input  logic [ghash_pkg::HW-1:0] b,
    output logic                     done,
    output logic [ghash_pkg::HW-1:0] prod
);

    logic [ghash_pkg::HW-1:0] a_reg, a_next, b_reg, b_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic                     run_reg, run_next;
    logic [61:0]              pp_reg, pp_next;
    logic [1:0]               kind_reg, kind_next;
    logic [63:0]              acc_reg, acc_next;
    logic                     done_reg, done_next;
    logic [ghash_pkg::HW-1:0] prod_reg, prod_next;

    logic [30:0] op_x, op_y;
    logic [63:0] fold;
    logic [61:0] red;

    // partial product select: low/high halves split at bit 31
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                op_x = a_reg[30:0];
                op_y = b_reg[30:0];
            end
            2'd1:
            begin
                op_x = a_reg[30:0];
                op_y = {1'b0, b_reg[60:31]};
            end
            2'd2:
            begin
                op_x = {1'b0, a_reg[60:31]};
                op_y = b_reg[30:0];
            end
            default:
            begin
                op_x = {1'b0, a_reg[60:31]};
                op_y = {1'b0, b_reg[60:31]};
            end
        endcase
    end

    // weight 2^0, 2^31 (folded via 2^61 == 1) and 2^62 (== 2)
    always_comb
    begin
        case (kind_reg)
            2'd0:    fold = {2'b00, pp_reg};
            2'd3:    fold = {1'b0, pp_reg, 1'b0};
            default: fold = 64'(pp_reg[61:30]) + 64'({pp_reg[29:0], 31'd0});
        endcase
        red = {59'd0, acc_reg[63:61]} + {1'b0, acc_reg[60:0]};
        if (red >= {1'b0, ghash_pkg::HMOD})
        begin
            red = red - {1'b0, ghash_pkg::HMOD};
        end
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        pp_next   = pp_reg;
        kind_next = kind_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            cnt_next = '0;
            run_next = 1'b1;
            acc_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg < 3'd4)
            begin
                pp_next   = 62'(op_x * op_y);
                kind_next = cnt_reg[1:0];
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_next = acc_reg + fold;
            end
            if (cnt_reg == 3'd5)
            begin
                prod_next = red[ghash_pkg::HW-1:0];
                done_next = 1'b1;
                run_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            pp_reg   <= '0;
            kind_reg <= '0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
            prod_reg <= '0;
        end
        else
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            pp_reg   <= pp_next;
            kind_reg <= kind_next;
            acc_reg  <= acc_next;
            done_reg <= done_next;
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[rtl/grid_rectangle_hash_core.sv]
// ----------------------------------------------------------------------------
// grid_rectangle_hash_core
// Two-dimensional rolling hash mod 2^61-1 over a loaded grid of cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A load (op 0)
// writes one cell in the accepting cycle, gives no result and never raises
// busy; op 3 is ignored likewise. A rejected query answers with done in the
// next cycle without raising busy. An accepted query does four prefix reads,
// then two modular products. A build runs the two Fermat exponentiations and
// the inverse power chains, then walks the grid once. All products go through
// one shared mod-P multiplier. After reset the MAX_ROWS*MAX_COLS cells of the
// cell store (4096 by default) are cleared with busy high; config writes are
// taken throughout. Results appear on result for exactly one cycle with done
// high and cannot be held off downstream.
// ----------------------------------------------------------------------------
module grid_rectangle_hash_core #(
    parameter int MAX_ROWS = ghash_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ghash_pkg::DEF_MAX_COLS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ghash_pkg::cmd_t          cmd,
    output logic                     done,
    output ghash_pkg::res_t          result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [ghash_pkg::HW-1:0] cfg_data
);

    localparam int HW     = ghash_pkg::HW;
    localparam int RW     = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int CW     = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int PDEPTH = (MAX_ROWS + 1) * (MAX_COLS + 1);
    localparam int CA     = ghash_pkg::addr_w(CELLS);
    localparam int PA     = ghash_pkg::addr_w(PDEPTH);
    localparam int RIA    = ghash_pkg::addr_w(MAX_ROWS + 1);
    localparam int CIA    = ghash_pkg::addr_w(MAX_COLS + 1);

    // one-hot sequencer
    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_CLEAR = 15'b000000000000010,
        ST_PSQ   = 15'b000000000000100,  // exponent: square
        ST_PML   = 15'b000000000001000,  // exponent: multiply
        ST_IWR   = 15'b000000000010000,  // write inverse power
        ST_ICH   = 15'b000000000100000,  // next inverse power down
        ST_GCL   = 15'b000000001000000,  // cell read settles
        ST_GM1   = 15'b000000010000000,  // cell * row power
        ST_GM2   = 15'b000000100000000,  // ... * column power
        ST_PRD   = 15'b000001000000000,  // prefix reads and add/sub
        ST_GWR   = 15'b000010000000000,  // prefix write
        ST_GP2   = 15'b000100000000000,  // column power step
        ST_GP1   = 15'b001000000000000,  // row power step
        ST_QM1   = 15'b010000000000000,  // sum * row inverse
        ST_QM2   = 15'b100000000000000   // ... * column inverse
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [HW-1:0] row_base_reg, row_base_next, col_base_reg, col_base_next;
    logic [6:0]    gh_reg, gh_next, gw_reg, gw_next;

    // build context
    logic [RW-1:0] h_reg, h_next, bh_reg, bh_next;
    logic [CW-1:0] w_reg, w_next, bw_reg, bw_next;
    logic          built_reg, built_next;
    logic [HW-1:0] b1_reg, b1_next, b2_reg, b2_next;
    logic [HW-1:0] a_reg, a_next, r_reg, r_next;
    logic [HW-1:0] e_reg, e_next;
    logic [6:0]    ecnt_reg, ecnt_next;
    logic          ph_reg, ph_next, sel_reg, sel_next;
    logic [RW-1:0] idx_reg, idx_next;          // wide enough for either table
    logic [RW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [HW-1:0] p1_reg, p1_next, p2_reg, p2_next, tmp_reg, tmp_next;
    logic [HW-1:0] acc_reg, acc_next;
    logic [2:0]    rc_reg, rc_next;
    logic          qmode_reg, qmode_next;
    logic          zf_reg, zf_next, subf_reg, subf_next;
    logic [RW-1:0] qsy_reg, qsy_next, qgy_reg, qgy_next;
    logic [CW-1:0] qsx_reg, qsx_next, qgx_reg, qgx_next;
    logic [CA-1:0] clr_reg, clr_next;
    logic          mpend_reg, mpend_next;

    // result
    logic            done_reg, done_next;
    ghash_pkg::res_t res_reg, res_next;

    // shared multiplier
    logic          mul_start, mul_done, mul_state;
    logic [HW-1:0] mul_a, mul_b, mul_prod;

    // memories
    logic          cell_we;
    logic [CA-1:0] cell_waddr, cell_raddr;
    logic [HW-1:0] cell_wdata, cell_rdata;
    logic          pre_we;
    logic [PA-1:0] pre_waddr, pre_raddr;
    logic [HW-1:0] pre_rdata;
    logic          rinv_we, cinv_we;
    logic [HW-1:0] rinv_rdata, cinv_rdata;

    // prefix read descriptor
    logic [RW-1:0] d_row;
    logic [CW-1:0] d_col;
    logic          d_sub;
    logic [2:0]    rd_count;
    logic [HW-1:0] rd_val;

    // transaction decode
    logic          accept;
    logic [RW-1:0] c_sy, c_gy, c_h;
    logic [CW-1:0] c_sx, c_gx, c_w;
    logic          q_ok;

    assign accept = start && (state_reg == ST_IDLE);
    assign c_sy   = RW'(cmd.top_row);
    assign c_gy   = RW'(cmd.bottom_row);
    assign c_sx   = CW'(cmd.left_col);
    assign c_gx   = CW'(cmd.right_col);
    assign q_ok   = built_reg && (c_sy <= c_gy) && (c_sx <= c_gx)
                    && (c_gy <= bh_reg) && (c_gx <= bw_reg);

    // sizes are clamped into [1, MAX] at build time
    assign c_h = (gh_reg == 7'd0) ? RW'(1)
               : ((RW'(gh_reg) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(gh_reg));
    assign c_w = (gw_reg == 7'd0) ? CW'(1)
               : ((CW'(gw_reg) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(gw_reg));

    // read schedule: build uses up, left, diagonal; query the four corners
    always_comb
    begin
        d_row = i_reg;
        d_col = j_reg;
        d_sub = 1'b0;
        if (qmode_reg)
        begin
            case (rc_reg[1:0])
                2'd0:
                begin
                    d_row = qgy_reg;
                    d_col = qgx_reg;
                end
                2'd1:
                begin
                    d_row = qgy_reg;
                    d_col = qsx_reg;
                    d_sub = 1'b1;
                end
                2'd2:
                begin
                    d_row = qsy_reg;
                    d_col = qgx_reg;
                    d_sub = 1'b1;
                end
                default:
                begin
                    d_row = qsy_reg;
                    d_col = qsx_reg;
                end
            endcase
        end
        else
        begin
            case (rc_reg[1:0])
                2'd0:    d_col = j_reg + CW'(1);
                2'd1:    d_row = i_reg + RW'(1);
                default: d_sub = 1'b1;
            endcase
        end
    end

    assign rd_count  = qmode_reg ? 3'd4 : 3'd3;
    // row 0 and column 0 of the prefix table are zero and never stored
    assign rd_val    = zf_reg ? '0 : pre_rdata;
    assign pre_raddr = PA'(d_row) * PA'(MAX_COLS + 1) + PA'(d_col);
    assign pre_waddr = PA'(i_reg + RW'(1)) * PA'(MAX_COLS + 1) + PA'(j_reg + CW'(1));
    assign pre_we    = (state_reg == ST_GWR);

    assign cell_raddr = CA'(i_reg) * CA'(MAX_COLS) + CA'(j_reg);
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            cell_we    = 1'b1;
            cell_waddr = clr_reg;
            cell_wdata = '0;
        end
        else
        begin
            cell_we    = accept && (cmd.operation == ghash_pkg::OP_LOAD)
                         && (RW'(cmd.cell_row) < RW'(MAX_ROWS))
                         && (CW'(cmd.cell_col) < CW'(MAX_COLS));
            cell_waddr = CA'(cmd.cell_row) * CA'(MAX_COLS) + CA'(cmd.cell_col);
            cell_wdata = ghash_pkg::mreduce(cmd.cell_value);
        end
    end

    assign rinv_we = (state_reg == ST_IWR) && !sel_reg;
    assign cinv_we = (state_reg == ST_IWR) && sel_reg;

    // multiplier operands by state
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = r_reg;
        mul_b     = r_reg;
        case (state_reg)
            ST_PSQ:  mul_b = r_reg;
            ST_PML:  mul_b = a_reg;
            ST_ICH:  mul_b = sel_reg ? b2_reg : b1_reg;
            ST_GM1:
            begin
                mul_a = cell_rdata;
                mul_b = p1_reg;
            end
            ST_GM2:
            begin
                mul_a = tmp_reg;
                mul_b = p2_reg;
            end
            ST_GP2:
            begin
                mul_a = p2_reg;
                mul_b = b2_reg;
            end
            ST_GP1:
            begin
                mul_a = p1_reg;
                mul_b = b1_reg;
            end
            ST_QM1:
            begin
                mul_a = acc_reg;
                mul_b = rinv_rdata;
            end
            ST_QM2:
            begin
                mul_a = acc_reg;
                mul_b = cinv_rdata;
            end
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_start = mul_state && !mpend_reg;

    always_comb
    begin
        state_next    = state_reg;
        row_base_next = row_base_reg;
        col_base_next = col_base_reg;
        gh_next       = gh_reg;
        gw_next       = gw_reg;
        h_next        = h_reg;
        w_next        = w_reg;
        bh_next       = bh_reg;
        bw_next       = bw_reg;
        built_next    = built_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        a_next        = a_reg;
        r_next        = r_reg;
        e_next        = e_reg;
        ecnt_next     = ecnt_reg;
        ph_next       = ph_reg;
        sel_next      = sel_reg;
        idx_next      = idx_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        tmp_next      = tmp_reg;
        acc_next      = acc_reg;
        rc_next       = rc_reg;
        qmode_next    = qmode_reg;
        zf_next       = zf_reg;
        subf_next     = subf_reg;
        qsy_next      = qsy_reg;
        qsx_next      = qsx_reg;
        qgy_next      = qgy_reg;
        qgx_next      = qgx_reg;
        clr_next      = clr_reg;
        mpend_next    = mpend_reg;
        done_next     = 1'b0;
        res_next      = res_reg;

        if (mul_start)
        begin
            mpend_next = 1'b1;
        end
        if (mul_done)
        begin
            mpend_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                ghash_pkg::CFG_ROW_BASE:    row_base_next = cfg_data;
                ghash_pkg::CFG_COL_BASE:    col_base_next = cfg_data;
                ghash_pkg::CFG_GRID_HEIGHT: gh_next = cfg_data[6:0];
                ghash_pkg::CFG_GRID_WIDTH:  gw_next = cfg_data[6:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.operation)
                        ghash_pkg::OP_BUILD:
                        begin
                            h_next     = c_h;
                            w_next     = c_w;
                            b1_next    = ghash_pkg::mreduce(row_base_reg);
                            b2_next    = ghash_pkg::mreduce(col_base_reg);
                            a_next     = ghash_pkg::mreduce(row_base_reg);
                            r_next     = HW'(1);
                            e_next     = ghash_pkg::FERMAT_EXP;
                            ecnt_next  = 7'(HW);
                            ph_next    = 1'b0;
                            sel_next   = 1'b0;
                            state_next = ST_PSQ;
                        end
                        ghash_pkg::OP_QUERY:
                        begin
                            if (q_ok)
                            begin
                                qsy_next   = c_sy;
                                qsx_next   = c_sx;
                                qgy_next   = c_gy;
                                qgx_next   = c_gx;
                                qmode_next = 1'b1;
                                acc_next   = '0;
                                rc_next    = '0;
                                state_next = ST_PRD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                res_next  = '{hash_value: '0,
                                              result_kind: ghash_pkg::KIND_REJECT};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + CA'(1);
                if (clr_reg == CA'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PSQ, ST_PML:
            begin
                if (mul_done)
                begin
                    r_next = mul_prod;
                    if ((state_reg == ST_PSQ) && e_reg[HW-1])
                    begin
                        state_next = ST_PML;
                    end
                    else
                    begin
                        e_next    = {e_reg[HW-2:0], 1'b0};
                        ecnt_next = ecnt_reg - 7'd1;
                        state_next = ST_PSQ;
                        if (ecnt_reg == 7'd1)
                        begin
                            if (!ph_reg)
                            begin
                                // raise the Fermat inverse to the table size
                                a_next    = mul_prod;
                                r_next    = HW'(1);
                                ph_next   = 1'b1;
                                if (sel_reg)
                                begin
                                    e_next    = {w_reg, {(HW - CW){1'b0}}};
                                    ecnt_next = 7'(CW);
                                end
                                else
                                begin
                                    e_next    = {h_reg, {(HW - RW){1'b0}}};
                                    ecnt_next = 7'(RW);
                                end
                            end
                            else
                            begin
                                idx_next   = sel_reg ? RW'(w_reg) : h_reg;
                                state_next = ST_IWR;
                            end
                        end
                    end
                end
            end
            ST_IWR:
            begin
                if (idx_reg == '0)
                begin
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        a_next     = b2_reg;
                        r_next     = HW'(1);
                        e_next     = ghash_pkg::FERMAT_EXP;
                        ecnt_next  = 7'(HW);
                        ph_next    = 1'b0;
                        state_next = ST_PSQ;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        p1_next    = HW'(1);
                        p2_next    = HW'(1);
                        qmode_next = 1'b0;
                        state_next = ST_GCL;
                    end
                end
                else
                begin
                    state_next = ST_ICH;
                end
            end
            ST_ICH:
            begin
                if (mul_done)
                begin
                    r_next     = mul_prod;
                    idx_next   = idx_reg - RW'(1);
                    state_next = ST_IWR;
                end
            end
            ST_GCL:
            begin
                state_next = ST_GM1;
            end
            ST_GM1:
            begin
                if (mul_done)
                begin
                    tmp_next   = mul_prod;
                    state_next = ST_GM2;
                end
            end
            ST_GM2:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_prod;
                    rc_next    = '0;
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                rc_next   = rc_reg + 3'd1;
                zf_next   = (d_row == '0) || (d_col == '0);
                subf_next = d_sub;
                if (rc_reg != '0)
                begin
                    acc_next = subf_reg ? ghash_pkg::msub(acc_reg, rd_val)
                                        : ghash_pkg::madd(acc_reg, rd_val);
                end
                if (rc_reg == rd_count)
                begin
                    state_next = qmode_reg ? ST_QM1 : ST_GWR;
                end
            end
            ST_GWR:
            begin
                state_next = ST_GP2;
            end
            ST_GP2:
            begin
                if (mul_done)
                begin
                    p2_next = mul_prod;
                    if (j_reg == w_reg - CW'(1))
                    begin
                        state_next = ST_GP1;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = ST_GCL;
                    end
                end
            end
            ST_GP1:
            begin
                if (mul_done)
                begin
                    p1_next = mul_prod;
                    p2_next = HW'(1);
                    j_next  = '0;
                    if (i_reg == h_reg - RW'(1))
                    begin
                        bh_next    = h_reg;
                        bw_next    = w_reg;
                        built_next = 1'b1;
                        done_next  = 1'b1;
                        res_next   = '{hash_value: '0,
                                       result_kind: ghash_pkg::KIND_BUILD};
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + RW'(1);
                        state_next = ST_GCL;
                    end
                end
            end
            ST_QM1:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_prod;
                    state_next = ST_QM2;
                end
            end
            ST_QM2:
            begin
                if (mul_done)
                begin
                    done_next  = 1'b1;
                    res_next   = '{hash_value: mul_prod,
                                   result_kind: ghash_pkg::KIND_HASH};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            row_base_reg <= ghash_pkg::ROW_BASE_RST;
            col_base_reg <= ghash_pkg::COL_BASE_RST;
            gh_reg       <= ghash_pkg::GRID_DIM_RST;
            gw_reg       <= ghash_pkg::GRID_DIM_RST;
            h_reg        <= '0;
            w_reg        <= '0;
            bh_reg       <= '0;
            bw_reg       <= '0;
            built_reg    <= 1'b0;
            b1_reg       <= '0;
            b2_reg       <= '0;
            a_reg        <= '0;
            r_reg        <= '0;
            e_reg        <= '0;
            ecnt_reg     <= '0;
            ph_reg       <= 1'b0;
            sel_reg      <= 1'b0;
            idx_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            tmp_reg      <= '0;
            acc_reg      <= '0;
            rc_reg       <= '0;
            qmode_reg    <= 1'b0;
            zf_reg       <= 1'b0;
            subf_reg     <= 1'b0;
            qsy_reg      <= '0;
            qsx_reg      <= '0;
            qgy_reg      <= '0;
            qgx_reg      <= '0;
            clr_reg      <= '0;
            mpend_reg    <= 1'b0;
            done_reg     <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_base_reg <= row_base_next;
            col_base_reg <= col_base_next;
            gh_reg       <= gh_next;
            gw_reg       <= gw_next;
            h_reg        <= h_next;
            w_reg        <= w_next;
            bh_reg       <= bh_next;
            bw_reg       <= bw_next;
            built_reg    <= built_next;
            b1_reg       <= b1_next;
            b2_reg       <= b2_next;
            a_reg        <= a_next;
            r_reg        <= r_next;
            e_reg        <= e_next;
            ecnt_reg     <= ecnt_next;
            ph_reg       <= ph_next;
            sel_reg      <= sel_next;
            idx_reg      <= idx_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            tmp_reg      <= tmp_next;
            acc_reg      <= acc_next;
            rc_reg       <= rc_next;
            qmode_reg    <= qmode_next;
            zf_reg       <= zf_next;
            subf_reg     <= subf_next;
            qsy_reg      <= qsy_next;
            qsx_reg      <= qsx_next;
            qgy_reg      <= qgy_next;
            qgx_reg      <= qgx_next;
            clr_reg      <= clr_next;
            mpend_reg    <= mpend_next;
            done_reg     <= done_next;
            res_reg      <= res_next;
        end
    end

    ghash_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ghash_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_cells (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    ghash_ram #(.WIDTH(HW), .DEPTH(PDEPTH)) u_prefix (
        .clk   (clk),
        .we    (pre_we),
        .waddr (pre_waddr),
        .wdata (acc_reg),
        .raddr (pre_raddr),
        .rdata (pre_rdata)
    );

    ghash_ram #(.WIDTH(HW), .DEPTH(MAX_ROWS + 1)) u_row_inv (
        .clk   (clk),
        .we    (rinv_we),
        .waddr (idx_reg[RIA-1:0]),
        .wdata (r_reg),
        .raddr (qsy_reg[RIA-1:0]),
        .rdata (rinv_rdata)
    );

    ghash_ram #(.WIDTH(HW), .DEPTH(MAX_COLS + 1)) u_col_inv (
        .clk   (clk),
        .we    (cinv_we),
        .waddr (idx_reg[CIA-1:0]),
        .wdata (r_reg),
        .raddr (qsx_reg[CIA-1:0]),
        .rdata (cinv_rdata)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

`ifndef NO_ASSERTIONS
    a_hash_needs_tables: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.result_kind == ghash_pkg::KIND_HASH) |-> built_reg)
        else $error("hash result without built tables");

    a_zero_unless_hash: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.result_kind != ghash_pkg::KIND_HASH) |-> (result.hash_value == '0))
        else $error("non-hash result carries a value");

    a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hash_value < ghash_pkg::HMOD))
        else $error("hash not fully reduced");

    a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> !mul_start)
        else $error("multiplier restarted while running");
`endif

endmodule

[dv/tb_grid_rectangle_hash_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_rectangle_hash_core
// Self-checking bench for the 2-D rolling hash core: cell loads, table builds
// and rectangle queries, checked against an in-bench mod 2^61-1 hash model.
// ----------------------------------------------------------------------------
module tb_grid_rectangle_hash_core;
    import ghash_pkg::*;

    localparam int NR = DEF_MAX_ROWS;
    localparam int NC = DEF_MAX_COLS;
    localparam int STALL_LIMIT = 400000;  // longer than the quiet stretch of the largest build

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [HW-1:0] cfg_data;

    grid_rectangle_hash_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Hash model state: register copies, cells, prefix sums, inverse powers
    // ------------------------------------------------------------------
    logic [HW-1:0] m_row_base, m_col_base;
    logic [6:0]    m_height, m_width;
    logic [HW-1:0] m_cell [NR][NC];
    logic [HW-1:0] m_sum  [NR+1][NC+1];
    logic [HW-1:0] m_rinv [NR+1];
    logic [HW-1:0] m_cinv [NC+1];
    bit            m_built;
    int            m_bh, m_bw;

    res_t pending_hashes[$];   // results still owed by the core
    int   errors;
    int   n_items, n_results, n_builds, n_hashes, n_rejects;
    int   idle_pct;
    int   stall_cnt;

    // full product then a single remainder; operands always below P
    function automatic logic [HW-1:0] mulp(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [2*HW-1:0] p;
        p = {{HW{1'b0}}, a} * {{HW{1'b0}}, b};
        return HW'(p % {{HW{1'b0}}, HMOD});
    endfunction

    function automatic logic [HW-1:0] powp(input logic [HW-1:0] a, input logic [HW-1:0] e);
        logic [HW-1:0] r;
        r = 1;
        for (int k = 0; k < HW; k++)
        begin
            if (e[k])
                r = mulp(r, a);
            a = mulp(a, a);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] addp(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [HW+1:0] s;
        s = a + b;
        return HW'(s % HMOD);
    endfunction

    function automatic logic [HW-1:0] subp(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [HW+1:0] s;
        s = a + HMOD - b;
        return HW'(s % HMOD);
    endfunction

    // 2^61-1 itself is the only 61-bit value not already below P
    function automatic logic [HW-1:0] foldp(input logic [HW-1:0] v);
        return (v == HMOD) ? '0 : v;
    endfunction

    function automatic int clamp_dim(input logic [6:0] v, input int maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    task automatic build_model();
        logic [HW-1:0] b1, b2, pr, pc, v, s;
        int h, w;
        h  = clamp_dim(m_height, NR);
        w  = clamp_dim(m_width, NC);
        b1 = foldp(m_row_base);
        b2 = foldp(m_col_base);
        // inverse at the far end by Fermat, then step back by the base
        m_rinv[h] = powp(powp(b1, FERMAT_EXP), HW'(h));
        for (int i = h; i > 0; i--)
            m_rinv[i-1] = mulp(b1, m_rinv[i]);
        m_cinv[w] = powp(powp(b2, FERMAT_EXP), HW'(w));
        for (int j = w; j > 0; j--)
            m_cinv[j-1] = mulp(b2, m_cinv[j]);
        for (int i = 0; i <= NR; i++)
            for (int j = 0; j <= NC; j++)
                m_sum[i][j] = '0;
        pr = 1;
        for (int i = 0; i < h; i++)
        begin
            pc = 1;
            for (int j = 0; j < w; j++)
            begin
                v = mulp(mulp(m_cell[i][j], pr), pc);
                s = addp(addp(v, m_sum[i][j+1]), m_sum[i+1][j]);
                m_sum[i+1][j+1] = subp(s, m_sum[i][j]);
                pc = mulp(pc, b2);
            end
            pr = mulp(pr, b1);
        end
        m_bh = h;
        m_bw = w;
        m_built = 1;
    endtask

    // apply one accepted command to the model; returns 1 when a result is owed
    task automatic predict_hash(input cmd_t c, output bit owed, output res_t r);
        logic [HW-1:0] s;
        owed = 0;
        r = '0;
        case (c.operation)
            OP_LOAD:
                m_cell[c.cell_row][c.cell_col] = foldp(c.cell_value);
            OP_BUILD:
            begin
                build_model();
                owed = 1;
                r.result_kind = KIND_BUILD;
            end
            OP_QUERY:
            begin
                owed = 1;
                if (!m_built || c.top_row > c.bottom_row || c.left_col > c.right_col ||
                    c.bottom_row > m_bh || c.right_col > m_bw)
                begin
                    r.result_kind = KIND_REJECT;
                end
                else
                begin
                    s = subp(m_sum[c.bottom_row][c.right_col], m_sum[c.bottom_row][c.left_col]);
                    s = subp(s, m_sum[c.top_row][c.right_col]);
                    s = addp(s, m_sum[c.top_row][c.left_col]);
                    r.hash_value  = mulp(mulp(s, m_rinv[c.top_row]), m_cinv[c.left_col]);
                    r.result_kind = KIND_HASH;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // counts edges at which neither a command nor a result moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: sampled mid-cycle, the strobe lasts one whole cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_hashes.size() == 0)
            begin
                report("unexpected result kind", 64'(result.result_kind), 64'hx);
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (result.result_kind !== want.result_kind)
                    report("result_kind", 64'(result.result_kind), 64'(want.result_kind));
                if (result.hash_value !== want.hash_value)
                    report("hash_value", 64'(result.hash_value), 64'(want.hash_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // start is left high after a transaction; it only drops for a gap or in wait_idle
    task automatic send_cmd(input cmd_t c, input bit typed, input res_t typed_res);
        bit   owed;
        res_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        predict_hash(c, owed, r);
        if (owed)
            pending_hashes.push_back(typed ? typed_res : r);
        if (c.operation != 2'd3)
            n_items++;
        if (c.operation == OP_BUILD)
            n_builds++;
        if (owed && r.result_kind == KIND_HASH)
            n_hashes++;
        if (owed && r.result_kind == KIND_REJECT)
            n_rejects++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (pending_hashes.size() == 0 && !busy)
                break;
        end
        repeat (40) @(posedge clk);   // covers a trailing load
    endtask

    task automatic write_regs(input logic [HW-1:0] rb, input logic [HW-1:0] cb,
                              input logic [6:0] gh, input logic [6:0] gw);
        logic [HW-1:0] vals [4];
        logic [1:0]    idx [4];
        vals = '{rb, cb, HW'(gh), HW'(gw)};
        idx  = '{CFG_ROW_BASE, CFG_COL_BASE, CFG_GRID_HEIGHT, CFG_GRID_WIDTH};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            forever
            begin
                @(negedge clk);
                if (cfg_ready)
                    break;
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        m_row_base = rb;
        m_col_base = cb;
        m_height   = gh;
        m_width    = gw;
    endtask

    function automatic cmd_t mk(input logic [1:0] op, input int r, input int c,
                                input logic [HW-1:0] v, input int t, input int l,
                                input int b, input int rc);
        cmd_t x;
        x.operation  = op;
        x.cell_row   = 6'(r);
        x.cell_col   = 6'(c);
        x.cell_value = v;
        x.top_row    = 7'(t);
        x.left_col   = 7'(l);
        x.bottom_row = 7'(b);
        x.right_col  = 7'(rc);
        return x;
    endfunction

    function automatic logic [HW-1:0] rand_value();
        case ($urandom_range(9))
            0: return HMOD;
            1: return HMOD - 1;
            2: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random command, mostly loads inside the grid and well-formed queries
    function automatic cmd_t rand_cmd();
        int sel, y0, y1, x0, x1, h, w;
        sel = $urandom_range(99);
        h = clamp_dim(m_height, NR);
        w = clamp_dim(m_width, NC);
        if (sel < 55)
        begin
            if ($urandom_range(9) == 0)
                return mk(OP_LOAD, $urandom_range(63), $urandom_range(63), rand_value(), 0, 0, 0, 0);
            return mk(OP_LOAD, $urandom_range(h-1), $urandom_range(w-1), rand_value(),
                      $urandom_range(127), $urandom_range(127), $urandom_range(127),
                      $urandom_range(127));
        end
        if (sel < 63)
            return mk(OP_BUILD, $urandom_range(63), $urandom_range(63), rand_value(), 0, 0, 0, 0);
        if (sel < 96)
        begin
            if (m_built && $urandom_range(99) < 85)
            begin
                y0 = $urandom_range(m_bh); y1 = $urandom_range(m_bh);
                x0 = $urandom_range(m_bw); x1 = $urandom_range(m_bw);
                if (y0 > y1) begin sel = y0; y0 = y1; y1 = sel; end
                if (x0 > x1) begin sel = x0; x0 = x1; x1 = sel; end
                return mk(OP_QUERY, $urandom_range(63), $urandom_range(63), rand_value(),
                          y0, x0, y1, x1);
            end
            return mk(OP_QUERY, 0, 0, '0, $urandom_range(127), $urandom_range(127),
                      $urandom_range(127), $urandom_range(127));
        end
        return mk(2'd3, $urandom_range(63), $urandom_range(63), rand_value(), 0, 0, 0, 0);
    endfunction

    // ------------------------------------------------------------------
    // Directed table: typed result where it is plain, model otherwise
    // ------------------------------------------------------------------
    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    localparam res_t R_REJ   = '{hash_value: '0, result_kind: KIND_REJECT};
    localparam res_t R_BUILT = '{hash_value: '0, result_kind: KIND_BUILD};
    localparam res_t R_EMPTY = '{hash_value: '0, result_kind: KIND_HASH};
    localparam res_t R_NONE  = '{hash_value: '0, result_kind: KIND_BUILD};

    row_t rows [$];

    typedef struct {
        logic [HW-1:0] rb, cb;
        logic [6:0]    gh, gw;
        int            pct;
    } setting_t;

    initial
    begin
        setting_t plan [8];
        cmd_t c;

        start = 0; cmd = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        rst_n = 0;
        errors = 0; n_items = 0; n_results = 0; n_builds = 0; n_hashes = 0; n_rejects = 0;
        stall_cnt = 0;
        m_row_base = ROW_BASE_RST; m_col_base = COL_BASE_RST;
        m_height = GRID_DIM_RST; m_width = GRID_DIM_RST;
        for (int i = 0; i < NR; i++)
            for (int j = 0; j < NC; j++)
                m_cell[i][j] = '0;
        m_built = 0; m_bh = 0; m_bw = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        rows = '{
            '{mk(OP_QUERY, 0, 0, '0, 0, 0, 0, 0), 1, R_REJ},           // before any build
            '{mk(2'd3, 63, 63, HMOD, 0, 0, 0, 0), 0, R_NONE},           // unused code
            '{mk(OP_LOAD, 63, 63, HMOD, 0, 0, 0, 0), 0, R_NONE},        // 2^61-1 reads as zero
            '{mk(OP_LOAD, 0, 0, HMOD - 1, 0, 0, 0, 0), 0, R_NONE},
            '{mk(OP_LOAD, 0, 63, 61'h0AAA_AAAA_AAAA_AAAA, 0, 0, 0, 0), 0, R_NONE},
            '{mk(OP_LOAD, 63, 0, 61'h1555_5555_5555_5555, 127, 127, 127, 127), 0, R_NONE},
            '{mk(OP_LOAD, 31, 42, 61'd12345, 0, 0, 0, 0), 0, R_NONE},
            '{mk(OP_BUILD, 0, 0, '0, 0, 0, 0, 0), 1, R_BUILT},          // full 64 x 64
            '{mk(OP_QUERY, 0, 0, '0, 0, 0, 64, 64), 0, R_NONE},         // whole grid
            '{mk(OP_QUERY, 0, 0, '0, 63, 63, 64, 64), 0, R_NONE},       // corner cell
            '{mk(OP_QUERY, 0, 0, '0, 0, 0, 1, 1), 0, R_NONE},
            '{mk(OP_QUERY, 0, 0, '0, 10, 20, 10, 40), 1, R_EMPTY},      // empty rectangle
            '{mk(OP_QUERY, 0, 0, '0, 64, 64, 64, 64), 1, R_EMPTY},
            '{mk(OP_QUERY, 0, 0, '0, 5, 0, 4, 8), 1, R_REJ},            // top below bottom
            '{mk(OP_QUERY, 0, 0, '0, 0, 9, 8, 8), 1, R_REJ},            // left past right
            '{mk(OP_QUERY, 0, 0, '0, 0, 0, 65, 10), 1, R_REJ},          // beyond height
            '{mk(OP_QUERY, 0, 0, '0, 0, 0, 10, 127), 1, R_REJ},         // beyond width
            '{mk(OP_LOAD, 31, 42, 61'd999, 0, 0, 0, 0), 0, R_NONE},     // load after build
            '{mk(OP_QUERY, 0, 0, '0, 31, 42, 32, 43), 0, R_NONE},       // still old value
            '{mk(OP_BUILD, 0, 0, '0, 0, 0, 0, 0), 1, R_BUILT},
            '{mk(OP_QUERY, 0, 0, '0, 31, 42, 32, 43), 0, R_NONE}
        };

        idle_pct = 31;
        foreach (rows[k])
            send_cmd(rows[k].c, rows[k].typed, rows[k].r);
        wait_idle();

        // register settings: base extremes, folded bases, clamped sizes
        plan[0] = '{{$urandom, $urandom} % HMOD, {$urandom, $urandom} % HMOD, 7'd4, 7'd5, 31};
        plan[1] = '{61'd2, 61'd2, 7'd1, 7'd1, 31};
        plan[2] = '{61'd2305843009213693948, 61'd2305843009213693948, 7'd0, 7'd127, 31};
        plan[3] = '{HMOD, '0, 7'd3, 7'd3, 55};
        plan[4] = '{{$urandom, $urandom}, {$urandom, $urandom}, 7'd8, 7'd8, 55};
        plan[5] = '{{$urandom, $urandom} % HMOD, 61'd2, 7'd64, 7'd2, 55};
        plan[6] = '{{$urandom, $urandom} % HMOD, {$urandom, $urandom} % HMOD, 7'd6, 7'd7, 0};
        plan[7] = '{HMOD - 1, HMOD, 7'd2, 7'd64, 0};

        foreach (plan[p])
        begin
            write_regs(plan[p].rb, plan[p].cb, plan[p].gh, plan[p].gw);
            idle_pct = plan[p].pct;
            // old tables still answer until the next build
            repeat (3)
            begin
                c = mk(OP_QUERY, 0, 0, '0, 0, 0, $urandom_range(m_bh), $urandom_range(m_bw));
                send_cmd(c, 0, R_NONE);
            end
            for (int k = 0; k < 85; k++)
            begin
                // a stretch with no gaps now and then
                if (k == 40 && idle_pct > 0)
                begin
                    idle_pct = 0;
                    for (int q = 0; q < 12; q++)
                        send_cmd(rand_cmd(), 0, R_NONE);
                    idle_pct = plan[p].pct;
                end
                send_cmd(rand_cmd(), 0, R_NONE);
            end
            send_cmd(mk(OP_BUILD, 0, 0, '0, 0, 0, 0, 0), 1, R_BUILT);
            send_cmd(mk(OP_QUERY, 0, 0, '0, 0, 0, m_bh, m_bw), 0, R_NONE);
            wait_idle();
        end

        while (pending_hashes.size() != 0)
            report("missing result kind", 64'hx, 64'(pending_hashes.pop_front().result_kind));

        $display("covered %0d commands: %0d builds, %0d hashes, %0d rejects, %0d results",
                 n_items, n_builds, n_hashes, n_rejects, n_results);
        $display("8 register settings incl. folded bases, clamped sizes; %0d errors", errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/ghash_pkg.sv
rtl/ghash_ram.sv
rtl/ghash_mulmod.sv
rtl/grid_rectangle_hash_core.sv
dv/tb_grid_rectangle_hash_core.sv
